>>> design/ptrp_pkg.sv
// ----------------------------------------------------------------------------
// ptrp_pkg: shared types and constants of the RGB PWM driver
// Opcodes, register indexes, level constants and the command passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrp_pkg;

   // input opcodes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_POTENTIAL = 2'd1;
   localparam logic [1:0] OP_WHITE     = 2'd2;

   // neuron modes
   localparam logic [1:0] MODE_IAF   = 2'd0;
   localparam logic [1:0] MODE_MOTOR = 2'd1;
   localparam logic [1:0] MODE_IZH   = 2'd2;

   // configuration register indexes
   localparam logic CSR_NEURON_MODE = 1'b0;
   localparam logic CSR_PWM_TOP     = 1'b1;

   localparam logic [7:0]  LEVEL_FULL       = 8'd24;
   localparam logic [7:0]  LEVEL_WHITE      = 8'd156;
   localparam logic [1:0]  NEURON_MODE_INIT = 2'd0;
   localparam logic [15:0] PWM_TOP_INIT     = 16'd200;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_TICK,
      CMD_SET
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
   } cmd_type;

endpackage

`default_nettype wire

>>> design/ptrp_channels.sv
// ----------------------------------------------------------------------------
// ptrp channels: valid/ready stream interfaces of the RGB PWM driver
// Request channel carries opcode and potential, response channel carries the
// pin levels and the current duty levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptrp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] potential;

   modport source (output valid, output opcode, output potential, input ready);
   modport sink   (input valid, input opcode, input potential, output ready);
endinterface

interface ptrp_rsp_if;
   logic       valid;
   logic       ready;
   logic       red_pin;
   logic       green_pin;
   logic       blue_pin;
   logic [7:0] red_duty;
   logic [7:0] green_duty;
   logic [7:0] blue_duty;

   modport source (output valid, output red_pin, output green_pin, output blue_pin,
                   output red_duty, output green_duty, output blue_duty, input ready);
   modport sink   (input valid, input red_pin, input green_pin, input blue_pin,
                   input red_duty, input green_duty, input blue_duty, output ready);
endinterface

`default_nettype wire

>>> design/ptrp_front.sv
// ----------------------------------------------------------------------------
// ptrp_front: request decode and colour mapping
// Classify each request beat and turn potentials into target levels.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrp_front (
   input  wire logic              [1:0] neuron_mode,
   ptrp_req_if.sink                     req,
   output ptrp_pkg::cmd_type            cmd,
   output logic                         cmd_valid,
   input  wire logic                    cmd_ready
);

   logic signed [15:0] p;
   logic [15:0]        neg;
   logic [6:0]         q;       // magnitude of a small negative potential
   logic [9:0]         pos;     // small positive potential
   logic [14:0]        m7;
   logic [13:0]        m10p;
   logic [13:0]        m10n;
   logic [21:0]        m24;
   logic [4:0]         d7;
   logic [3:0]         d10p;
   logic [3:0]         d10n;
   logic [5:0]         d24;
   logic [4:0]         q4;
   logic [4:0]         t;

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;

   // constant divisions as reciprocal multiplies, exact over the used ranges
   always_comb begin
      p    = req.potential;
      neg  = 16'(-p);
      q    = neg[6:0];
      pos  = p[9:0];
      m7   = 15'(pos[6:0]) * 15'd147;
      m10p = 14'(pos[6:0]) * 14'd103;
      m10n = 14'(q) * 14'd103;
      m24  = 22'(pos) * 22'd2731;
      d7   = m7[14:10];
      d10p = m10p[13:10];
      d10n = m10n[13:10];
      d24  = m24[21:16];
      q4   = q[6:2];
   end

   always_comb begin
      cmd.kind  = ptrp_pkg::CMD_HOLD;
      cmd.red   = 8'd0;
      cmd.green = 8'd0;
      cmd.blue  = 8'd0;
      t         = 5'd0;
      unique case (req.opcode)
         ptrp_pkg::OP_TICK: begin
            cmd.kind = ptrp_pkg::CMD_TICK;
         end
         ptrp_pkg::OP_WHITE: begin
            cmd.kind  = ptrp_pkg::CMD_SET;
            cmd.red   = ptrp_pkg::LEVEL_WHITE;
            cmd.green = ptrp_pkg::LEVEL_WHITE;
            cmd.blue  = ptrp_pkg::LEVEL_WHITE;
         end
         ptrp_pkg::OP_POTENTIAL: begin
            cmd.kind = ptrp_pkg::CMD_SET;
            unique case (neuron_mode)
               ptrp_pkg::MODE_IAF: begin
                  if (p < -16'sd99) begin
                     cmd.red = ptrp_pkg::LEVEL_FULL;
                  end else if (p < 16'sd0) begin
                     t         = {1'b0, d10n};
                     cmd.red   = 8'd14 + 8'(t);
                     cmd.green = 8'd10 - 8'(t);
                  end else if (p == 16'sd0) begin
                     cmd.red   = 8'd14;
                     cmd.green = 8'd8;
                  end else if (p <= 16'sd99) begin
                     cmd.red   = 8'd14 - 8'(d7);
                     cmd.green = 8'd8 + 8'(d10p);
                  end else begin
                     cmd.green = 8'd18;
                  end
               end
               ptrp_pkg::MODE_MOTOR: begin
                  if (p < -16'sd100) begin
                     cmd.blue = ptrp_pkg::LEVEL_FULL;
                  end else if (p < 16'sd0) begin
                     // quarter minus one, floor at zero
                     t        = (q4 == 5'd0) ? 5'd0 : q4 - 5'd1;
                     cmd.red  = ptrp_pkg::LEVEL_FULL - 8'(t);
                     cmd.blue = ptrp_pkg::LEVEL_FULL;
                  end else if (p == 16'sd0) begin
                     cmd.red  = ptrp_pkg::LEVEL_FULL;
                     cmd.blue = ptrp_pkg::LEVEL_FULL;
                  end else if (p <= 16'sd99) begin
                     t        = pos[6:2];
                     cmd.red  = ptrp_pkg::LEVEL_FULL;
                     cmd.blue = ptrp_pkg::LEVEL_FULL - 8'(t);
                  end else begin
                     cmd.red = ptrp_pkg::LEVEL_FULL;
                  end
               end
               ptrp_pkg::MODE_IZH: begin
                  if (p < -16'sd100) begin
                     cmd.blue = ptrp_pkg::LEVEL_FULL;
                  end else if (p < 16'sd0) begin
                     t         = (q4 > 5'd24) ? 5'd24 : q4;
                     cmd.green = ptrp_pkg::LEVEL_FULL - 8'(t);
                     cmd.blue  = 8'(t);
                  end else if (p == 16'sd0) begin
                     cmd.red = ptrp_pkg::LEVEL_FULL;
                  end else if (p <= 16'sd600) begin
                     t         = (d24 > 6'd24) ? 5'd24 : d24[4:0];
                     cmd.red   = ptrp_pkg::LEVEL_FULL - 8'(t);
                     cmd.green = 8'(t);
                  end else begin
                     cmd.green = ptrp_pkg::LEVEL_FULL;
                  end
               end
               default: begin
                  cmd.kind = ptrp_pkg::CMD_HOLD;
               end
            endcase
         end
         default: begin
            cmd.kind = ptrp_pkg::CMD_HOLD;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/ptrp_queue.sv
// ----------------------------------------------------------------------------
// ptrp_queue: two-entry command queue
// Decouple the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  ptrp_pkg::cmd_type      push_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output ptrp_pkg::cmd_type      pop_cmd
);

   ptrp_pkg::cmd_type entry_ff [2];
   logic              wptr_ff;
   logic              wptr_in;
   logic              rptr_ff;
   logic              rptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> design/ptrp_back.sv
// ----------------------------------------------------------------------------
// ptrp_back: PWM state and response register
// Apply commands to the levels, pins and tick counter; present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic       [15:0] pwm_top,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  ptrp_pkg::cmd_type      cmd,
   ptrp_rsp_if.source             rsp
);

   logic [7:0]  red_ff;
   logic [7:0]  red_in;
   logic [7:0]  green_ff;
   logic [7:0]  green_in;
   logic [7:0]  blue_ff;
   logic [7:0]  blue_in;
   logic [15:0] tick_ff;
   logic [15:0] tick_in;
   logic [2:0]  pins_ff;
   logic [2:0]  pins_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        fire;

   // state registers double as the response payload: a command is taken only
   // when the previous result has gone
   assign cmd_ready = !rsp_valid_ff || rsp.ready;
   assign fire      = cmd_valid && cmd_ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.red_pin    = pins_ff[0];
   assign rsp.green_pin  = pins_ff[1];
   assign rsp.blue_pin   = pins_ff[2];
   assign rsp.red_duty   = red_ff;
   assign rsp.green_duty = green_ff;
   assign rsp.blue_duty  = blue_ff;

   always_comb begin
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      tick_in      = tick_ff;
      pins_in      = pins_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
         case (cmd.kind)
            ptrp_pkg::CMD_TICK: begin
               pins_in[0] = (red_ff <= 8'(tick_ff) ) && (tick_ff[15:8] == 8'd0);
               pins_in[1] = (green_ff <= 8'(tick_ff)) && (tick_ff[15:8] == 8'd0);
               pins_in[2] = (blue_ff <= 8'(tick_ff) ) && (tick_ff[15:8] == 8'd0);
               if (tick_ff[15:8] != 8'd0) begin
                  pins_in = 3'b111;
               end
               tick_in = (tick_ff > pwm_top) ? 16'd0 : tick_ff + 16'd1;
            end
            ptrp_pkg::CMD_SET: begin
               red_in   = cmd.red;
               green_in = cmd.green;
               blue_in  = cmd.blue;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff       <= 8'd0;
         green_ff     <= 8'd0;
         blue_ff      <= 8'd0;
         tick_ff      <= 16'd0;
         pins_ff      <= 3'b111;
         rsp_valid_ff <= 1'b0;
      end else begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         tick_ff      <= tick_in;
         pins_ff      <= pins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/potential_to_rgb_pwm_top.sv
// ----------------------------------------------------------------------------
// potential_to_rgb_pwm_top: three-channel PWM driver for an RGB LED
// Maps a neuron potential to colour levels and generates the PWM pin levels.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns exactly one response beat per
// request, in order. A request is a tick (compare each level with the tick
// counter, drive the pin low while the level is above it, advance the
// counter), a potential (map to red/green/blue levels by the neuron mode) or
// white (all levels 156); opcode 3, and a potential under neuron mode 3,
// leave the state alone but still answer. The front end decodes and maps
// in the accept cycle and writes a two-entry command queue; the back end
// takes commands from the queue, applies one command per cycle when the
// response register is free and registers the response beat. Sustained
// rate is one beat per clock as long as the response side takes beats;
// when it stalls, the queue absorbs two more requests before req ready drops.
// Configuration (neuron_mode at index 0, pwm_top at index 1) is written
// through csr_we/csr_index/csr_wdata and must only change while no request
// is in flight. The pins power up high (LEDs off) and all levels at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module potential_to_rgb_pwm_top (
   input  wire logic        clock,
   input  wire logic        reset,
   ptrp_req_if.sink         req_if,
   ptrp_rsp_if.source       rsp_if,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [1:0]        neuron_mode_ff;
   logic [1:0]        neuron_mode_in;
   logic [15:0]       pwm_top_ff;
   logic [15:0]       pwm_top_in;

   ptrp_pkg::cmd_type front_cmd;
   logic              front_valid;
   logic              front_ready;
   ptrp_pkg::cmd_type back_cmd;
   logic              back_valid;
   logic              back_ready;

   // register writes; only the low bits of the neuron mode write are kept
   always_comb begin
      neuron_mode_in = neuron_mode_ff;
      pwm_top_in     = pwm_top_ff;
      if (csr_we) begin
         case (csr_index)
            ptrp_pkg::CSR_NEURON_MODE: neuron_mode_in = csr_wdata[1:0];
            ptrp_pkg::CSR_PWM_TOP:     pwm_top_in     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neuron_mode_ff <= ptrp_pkg::NEURON_MODE_INIT;
         pwm_top_ff     <= ptrp_pkg::PWM_TOP_INIT;
      end else begin
         neuron_mode_ff <= neuron_mode_in;
         pwm_top_ff     <= pwm_top_in;
      end
   end

   // decode and map the request beat
   ptrp_front u_front (
      .neuron_mode (neuron_mode_ff),
      .req         (req_if),
      .cmd         (front_cmd),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready)
   );

   // hold up to two commands between front and back
   ptrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   // advance levels, pins and counter; drive the response beat
   ptrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pwm_top   (pwm_top_ff),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire

>>> design/ptrp_check.sv
// ----------------------------------------------------------------------------
// ptrp_check: port-level checks of the RGB PWM driver
// Watches the response channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrp_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       red_pin,
   input wire logic       green_pin,
   input wire logic       blue_pin,
   input wire logic [7:0] red_duty,
   input wire logic [7:0] green_duty,
   input wire logic [7:0] blue_duty
);

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // levels are either on the colour scale or the white level
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((red_duty <= 8'd24 || red_duty == 8'd156)
                  && (green_duty <= 8'd24 || green_duty == 8'd156)
                  && (blue_duty <= 8'd24 || blue_duty == 8'd156)))
      else $error("duty level outside legal set");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({red_pin, green_pin, blue_pin,
                                           red_duty, green_duty, blue_duty}))
      else $error("response payload changed while stalled");

endmodule

bind potential_to_rgb_pwm_top ptrp_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .red_pin    (rsp_if.red_pin),
   .green_pin  (rsp_if.green_pin),
   .blue_pin   (rsp_if.blue_pin),
   .red_duty   (rsp_if.red_duty),
   .green_duty (rsp_if.green_duty),
   .blue_duty  (rsp_if.blue_duty)
);

`default_nettype wire
